// ===== rtl/sfr_pkg.sv =====
// Shared constants, types and controller/datapath command and status structs
// for the sensor frame receiver. No dependencies.
`default_nettype none

package sfr_pkg;

   localparam int FRAME_BYTES = 32;
   localparam int WORD_COUNT  = FRAME_BYTES / 2;
   localparam int BANK_DEPTH  = (FRAME_BYTES + 1) / 2;
   localparam int POS_W       = $clog2(FRAME_BYTES);
   localparam int ADDR_W      = POS_W - 1;
   localparam int WORD_W      = $clog2(WORD_COUNT);
   localparam int BYTE_W      = 8;
   localparam int DATA_W      = 16;
   localparam int INDEX_W     = 4;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [DATA_W-1:0]  data_type;
   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [INDEX_W-1:0] index_type;

   // Header bytes and their positions
   localparam byte_type HDR_BYTE0   = 8'h42;
   localparam byte_type HDR_BYTE1   = 8'h4d;
   localparam byte_type HDR_LEN_VAL = 8'd28;
   localparam pos_type  HDR0_POS    = pos_type'(0);
   localparam pos_type  HDR1_POS    = pos_type'(1);
   localparam pos_type  HDR_LEN_POS = pos_type'(3);

   // Transmitted checksum sits in the last two bytes of the frame
   localparam pos_type  CHK_HI_POS  = pos_type'(FRAME_BYTES - 2);
   localparam pos_type  LAST_POS    = pos_type'(FRAME_BYTES - 1);
   localparam word_type LAST_WORD   = word_type'(WORD_COUNT - 1);

   typedef struct packed {
      logic      byte_take;
      logic      rd_en;
      addr_type  rd_addr;
      index_type rd_index;
      logic      rd_last;
   } cmd_type;

   typedef struct packed {
      logic frame_done;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/sfr_req_if.sv =====
// Byte channel into the sensor frame receiver: valid/ready plus one received byte.
// Depends on sfr_pkg.
`default_nettype none

interface sfr_req_if import sfr_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/sfr_rsp_if.sv =====
// Word channel out of the sensor frame receiver: valid/ready plus frame word fields.
// Depends on sfr_pkg.
`default_nettype none

interface sfr_rsp_if import sfr_pkg::*; ();
   logic      valid;
   logic      ready;
   data_type  frame_word;
   index_type word_index;
   logic      last_word;
   logic      checksum_ok;

   modport source (output valid, output frame_word, output word_index,
                   output last_word, output checksum_ok, input ready);
   modport sink   (input valid, input frame_word, input word_index,
                   input last_word, input checksum_ok, output ready);
endinterface

`default_nettype wire

// ===== rtl/sfr_ctrl.sv =====
// Controller for the sensor frame receiver: collect/burst state machine,
// word counter and output valid. Depends on sfr_pkg.
`default_nettype none

module sfr_ctrl import sfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic {
      ST_COLLECT,
      ST_BURST
   } state_type;

   state_type state_ff;
   word_type  word_ff;
   logic      rsp_valid_ff;

   always_comb begin
      req_ready     = (state_ff == ST_COLLECT);
      cmd.byte_take = req_valid && req_ready;
      // During the burst, read the next word whenever the output register is empty or drains
      cmd.rd_en     = (state_ff == ST_BURST) && (!rsp_valid_ff || rsp_ready);
      cmd.rd_addr   = addr_type'(word_ff);
      cmd.rd_index  = index_type'(word_ff);
      cmd.rd_last   = (word_ff == LAST_WORD);
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_COLLECT: begin
               if (status.frame_done) begin
                  state_ff <= ST_BURST;
                  word_ff  <= '0;
               end
            end
            ST_BURST: begin
               if (cmd.rd_en) begin
                  word_ff <= word_ff + word_type'(1);
                  if (cmd.rd_last) begin
                     state_ff <= ST_COLLECT;
                  end
               end
            end
            default: begin
               state_ff <= ST_COLLECT;
            end
         endcase

         if (cmd.rd_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_done_only_collect: assert property (@(posedge clock) disable iff (reset)
      status.frame_done |-> state_ff == ST_COLLECT)
      else $error("frame completed outside collect state");

   a_burst_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      status.frame_done |=> (state_ff == ST_BURST && word_ff == '0))
      else $error("burst did not start at word zero");

   a_burst_ends_on_last: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en && cmd.rd_last |=> state_ff == ST_COLLECT && rsp_valid_ff)
      else $error("burst did not end after last word read");

endmodule

`default_nettype wire

// ===== rtl/sfr_dp.sv =====
// Datapath for the sensor frame receiver: byte position, header check, running
// sum, checksum compare, even/odd frame store and output registers. Depends on sfr_pkg.
`default_nettype none

module sfr_dp import sfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  byte_type   rx_byte,
   output data_type   frame_word,
   output index_type  word_index,
   output logic       last_word,
   output logic       checksum_ok
);

   pos_type   pos_ff;
   pos_type   pos_in;
   data_type  sum_ff;
   data_type  sum_in;
   byte_type  chk_hi_ff;
   logic      ok_ff;
   logic      hdr_bad;
   logic      frame_done;
   addr_type  wr_addr;

   byte_type  even_mem [BANK_DEPTH];
   byte_type  odd_mem  [BANK_DEPTH];

   data_type  out_word_ff;
   index_type out_index_ff;
   logic      out_last_ff;
   logic      out_ok_ff;

   always_comb begin
      hdr_bad = ((pos_ff == HDR0_POS)    && (rx_byte != HDR_BYTE0)) ||
                ((pos_ff == HDR1_POS)    && (rx_byte != HDR_BYTE1)) ||
                ((pos_ff == HDR_LEN_POS) && (rx_byte != HDR_LEN_VAL));
      frame_done        = cmd.byte_take && (pos_ff == LAST_POS);
      status.frame_done = frame_done;
      wr_addr           = pos_ff[POS_W-1:1];

      pos_in = pos_ff;
      sum_in = sum_ff;
      if (cmd.byte_take) begin
         if (hdr_bad || frame_done) begin
            pos_in = '0;
            sum_in = '0;
         end else begin
            pos_in = pos_ff + pos_type'(1);
            if (pos_ff < CHK_HI_POS) begin
               sum_in = sum_ff + data_type'(rx_byte);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   // Hold the high checksum byte; compare on the final byte
   always_ff @(posedge clock) begin
      if (cmd.byte_take && pos_ff == CHK_HI_POS) begin
         chk_hi_ff <= rx_byte;
      end
      if (frame_done) begin
         ok_ff <= ({chk_hi_ff, rx_byte} == sum_ff);
      end
   end

   // Frame store: even bytes and odd bytes in two banks, one word per address
   always_ff @(posedge clock) begin
      if (cmd.byte_take && !hdr_bad) begin
         if (pos_ff[0]) begin
            odd_mem[wr_addr] <= rx_byte;
         end else begin
            even_mem[wr_addr] <= rx_byte;
         end
      end
   end

   // Registered read doubles as the output register
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         out_word_ff  <= {even_mem[cmd.rd_addr], odd_mem[cmd.rd_addr]};
         out_index_ff <= cmd.rd_index;
         out_last_ff  <= cmd.rd_last;
         out_ok_ff    <= ok_ff;
      end
   end

   assign frame_word  = out_word_ff;
   assign word_index  = out_index_ff;
   assign last_word   = out_last_ff;
   assign checksum_ok = out_ok_ff;

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_POS)
      else $error("byte position beyond frame");

   a_bad_header_restarts: assert property (@(posedge clock) disable iff (reset)
      cmd.byte_take && hdr_bad |=> pos_ff == '0 && sum_ff == '0)
      else $error("bad header byte did not restart the hunt");

   a_done_restarts: assert property (@(posedge clock) disable iff (reset)
      frame_done |=> pos_ff == '0 && sum_ff == '0)
      else $error("completed frame did not restart the hunt");

endmodule

`default_nettype wire

// ===== rtl/sensor_frame_receiver.sv =====
// Sensor frame receiver: one byte per cycle while hunting/collecting a frame.
// After the edge that takes the final byte the controller enters its burst state; word 0
// reaches rsp_ch once a read loads the output register. Throughput: 16 words leave one per
// cycle (rsp_ch stalls hold the burst); req_ch is held off for the burst.
// Reset (synchronous, active high) restarts the hunt at byte 0; the frame store is not cleared.
`default_nettype none

module sensor_frame_receiver import sfr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   sfr_req_if.sink      req_ch,
   sfr_rsp_if.source    rsp_ch
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       rsp_valid;

   // Controller: accept bytes while collecting, sequence the word burst
   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: check header, sum bytes, store frame, drive word payload
   sfr_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .rx_byte     (req_ch.rx_byte),
      .frame_word  (rsp_ch.frame_word),
      .word_index  (rsp_ch.word_index),
      .last_word   (rsp_ch.last_word),
      .checksum_ok (rsp_ch.checksum_ok)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

endmodule

`default_nettype wire
